[rtl/pal_pkg.sv]
// Shared types, request and status codes for the positional array list.
package pal_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int REQ_W            = 3;
   localparam int POS_W            = 4;
   localparam int STATUS_W         = 3;

   localparam logic [REQ_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [REQ_W-1:0] OP_DELETE  = 3'd1;
   localparam logic [REQ_W-1:0] OP_UPDATE  = 3'd2;
   localparam logic [REQ_W-1:0] OP_SEARCH  = 3'd3;
   localparam logic [REQ_W-1:0] OP_DISPLAY = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

   // Per-cell load select; at most one is set in a cycle.
   typedef struct packed {
      logic take_new;
      logic take_left;
      logic take_right;
   } cell_ctl_type;

endpackage

[rtl/pal_cell.sv]
// One storage cell of the list chain: loads a new value or a neighbor's value.
module pal_cell (
   input  logic                         clock,
   input  pal_pkg::cell_ctl_type        ctl,
   input  logic [pal_pkg::VALUE_W-1:0]  new_val,
   input  logic [pal_pkg::VALUE_W-1:0]  left_val,
   input  logic [pal_pkg::VALUE_W-1:0]  right_val,
   output logic [pal_pkg::VALUE_W-1:0]  val
);
   import pal_pkg::*;

   logic [VALUE_W-1:0] val_ff;
   logic [VALUE_W-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (ctl.take_new) begin
         val_in = new_val;
      end else if (ctl.take_left) begin
         val_in = left_val;
      end else if (ctl.take_right) begin
         val_in = right_val;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

[rtl/positional_array_list.sv]
// Top level of the positional array list: cell chain, control and result register.
//
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of cells,
// one value per cell, plus an element count. Insert shifts the cells at and above
// the position up by one, delete shifts them down, update loads one cell; an
// unused request code gives no result. Search and display compare every cell at
// once when the transaction is taken, then rotate the whole chain one place per
// cycle, holding while the result side stalls a matching element in cell 0, so
// element k sits in cell 0 on scan step k and is sent from there; the rotation
// brings the list back home at the end. A search or display therefore holds the
// block until the rotation is through; a search with no match or a display of an
// empty list does not rotate. Results pass through one output register; a new
// request is taken only when that register is empty or its result is taken in
// the same cycle, so a result stalled on rsp_ready also holds off req_ready.
// Elements never written hold undefined data, but only entries below the count
// are ever read. Reset empties the list.
module positional_array_list #(
   parameter int CAPACITY = pal_pkg::DEFAULT_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pal_pkg::REQ_W-1:0]      req_type,
   input  logic [pal_pkg::POS_W-1:0]      req_position,
   input  logic signed [pal_pkg::VALUE_W-1:0] req_item_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pal_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pal_pkg::POS_W-1:0]      rsp_index_out,
   output logic signed [pal_pkg::VALUE_W-1:0] rsp_value_out,
   output logic                           rsp_last
);
   import pal_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);        // count width
   localparam int IW = $clog2(CAPACITY);            // scan index width
   localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;  // compare width

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_SCAN = 1'b1;

   // cell chain
   logic [VALUE_W-1:0] cell_val [CAPACITY];
   cell_ctl_type       ctl      [CAPACITY];

   // control state
   logic                state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CAPACITY-1:0] mask_ff,  mask_in;     // elements still to send in this scan
   logic [IW-1:0]       idx_ff,   idx_in;      // element currently in cell 0

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_index_ff,  rsp_index_in;
   logic [VALUE_W-1:0]  rsp_value_ff,  rsp_value_in;
   logic                rsp_last_ff,   rsp_last_in;

   logic                accept;
   logic                out_free;
   logic                step;
   logic                emit;
   logic                full;
   logic                in_range;
   logic [WW-1:0]       pos_w;
   logic [WW-1:0]       cnt_w;
   logic [CAPACITY-1:0] scan_mask;
   logic [VALUE_W-1:0]  gone_val;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [VALUE_W-1:0] left_val;
         logic [VALUE_W-1:0] right_val;
         if (g == 0) begin : g_first
            assign left_val = '0;
         end else begin : g_mid
            assign left_val = cell_val[g-1];
         end
         // last cell wraps to cell 0 so a full rotation restores the list
         if (g == CAPACITY - 1) begin : g_wrap
            assign right_val = cell_val[0];
         end else begin : g_next
            assign right_val = cell_val[g+1];
         end
         pal_cell u_cell (
            .clock     (clock),
            .ctl       (ctl[g]),
            .new_val   (req_item_value),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[g])
         );
      end
   endgenerate

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == STATE_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign step      = (state_ff == STATE_SCAN) && (!mask_ff[0] || out_free);

   assign pos_w    = WW'(req_position);
   assign cnt_w    = WW'(count_ff);
   assign full     = (count_ff >= CW'(CAPACITY));
   assign in_range = (pos_w < cnt_w);

   // elements a search or display will send, found in parallel at accept
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         scan_mask[i] = (WW'(i) < cnt_w) &&
                        ((req_type == OP_DISPLAY) || (cell_val[i] == req_item_value));
      end
   end

   // value removed by a delete; position reaches only the low cells
   always_comb begin
      gone_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if ((i < (1 << POS_W)) && (WW'(i) == pos_w)) begin
            gone_val = cell_val[i];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      emit          = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_index_in  = '0;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         ctl[i] = '0;
      end

      if (accept) begin
         case (req_type)
            OP_INSERT: begin
               emit         = 1'b1;
               rsp_index_in = req_position;
               if (full) begin
                  rsp_status_in = STAT_FULL;
               end else if (pos_w > cnt_w) begin
                  rsp_status_in = STAT_BADPOS;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     ctl[i].take_new  = (WW'(i) == pos_w);
                     ctl[i].take_left = (WW'(i) > pos_w) && (WW'(i) <= cnt_w);
                  end
                  count_in     = CW'(count_ff + 1'b1);
                  rsp_value_in = req_item_value;
               end
            end
            OP_DELETE: begin
               emit         = 1'b1;
               rsp_index_in = req_position;
               if (!in_range) begin
                  rsp_status_in = STAT_BADPOS;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     ctl[i].take_right = (WW'(i) >= pos_w) && (WW'(i + 1) < cnt_w);
                  end
                  count_in     = CW'(count_ff - 1'b1);
                  rsp_value_in = gone_val;
               end
            end
            OP_UPDATE: begin
               emit         = 1'b1;
               rsp_index_in = req_position;
               if (!in_range) begin
                  rsp_status_in = STAT_BADPOS;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     ctl[i].take_new = (WW'(i) == pos_w);
                  end
                  rsp_value_in = req_item_value;
               end
            end
            OP_SEARCH, OP_DISPLAY: begin
               if (scan_mask == '0) begin
                  emit          = 1'b1;
                  rsp_status_in = (req_type == OP_SEARCH) ? STAT_NOTFOUND : STAT_EMPTY;
               end else begin
                  state_in = STATE_SCAN;
                  mask_in  = scan_mask;
                  idx_in   = '0;
               end
            end
            default: begin
               // unused codes: dropped, no result
            end
         endcase
      end else if (step) begin
         // rotate the chain one place toward cell 0
         for (int i = 0; i < CAPACITY; i++) begin
            ctl[i].take_right = 1'b1;
         end
         mask_in = mask_ff >> 1;
         idx_in  = IW'(idx_ff + 1'b1);
         if (mask_ff[0]) begin
            emit          = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_index_in  = POS_W'(idx_ff);
            rsp_value_in  = cell_val[0];
            rsp_last_in   = ((mask_ff >> 1) == '0);
         end
         if (idx_ff == IW'(CAPACITY - 1)) begin
            state_in = STATE_IDLE;
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      idx_ff  <= idx_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_index_out = rsp_index_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == STATE_IDLE))
      else $error("request taken during a scan");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> (count_ff == $past(count_ff)))
      else $error("count changed without a transaction");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_SCAN && idx_ff == '0) |-> (mask_ff != '0))
      else $error("scan started with nothing to send");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten before it was taken");
`endif

endmodule
